### hdl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Types and constants shared by the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_BACKSLASH = 2'd1,
    MODE_HEX       = 2'd2,
    MODE_UNICODE   = 2'd3
  } dec_mode_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_END_ESC   = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
  localparam logic [2:0] ERR_BAD_UNI   = 3'd3;
  localparam logic [2:0] ERR_RANGE     = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd5;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } esd_in_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_error;
    logic [2:0] error_code;
    logic       last;
  } esd_out_t;

endpackage

### hdl/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Decodes backslash escapes in a byte stream, with UTF-8 encoding of \u, \U.
// ----------------------------------------------------------------------------
// One input beat is decoded in the cycle it is accepted and yields zero to four
// result beats, which are written at once into an eight-entry result queue;
// the output side drains one beat per cycle unless stalled. An input beat is
// accepted whenever at least four queue entries are free, so with no stall
// plain bytes and single escapes flow at one beat per cycle, and only runs of
// multi-byte UTF-8 results slow the input down to the rate at which the output
// drains the queue. The final result of each input beat is marked with last.
module escape_sequence_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  esd_pkg::esd_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output esd_pkg::esd_out_t out_data
);

  localparam int unsigned PTR_W = $clog2(esd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic esd_pkg::esd_out_t mk_byte(input logic [7:0] b);
    esd_pkg::esd_out_t r;
    r.byte_value = b;
    r.is_error   = 1'b0;
    r.error_code = esd_pkg::ERR_NONE;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic esd_pkg::esd_out_t mk_err(input logic [2:0] code);
    esd_pkg::esd_out_t r;
    r.byte_value = 8'h00;
    r.is_error   = 1'b1;
    r.error_code = code;
    r.last       = 1'b0;
    return r;
  endfunction

  esd_pkg::dec_mode_t mode_r, mode_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic [3:0]  need_r, need_nxt;
  logic [31:0] acc_r, acc_nxt;

  esd_pkg::esd_out_t queue_r [esd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  esd_pkg::esd_out_t res [esd_pkg::MAX_RESULTS];
  logic [2:0]  nres;
  logic [4:0]  hv;
  logic [3:0]  seen_inc;
  logic [31:0] cp;
  logic [7:0]  c;
  logic        in_fire;
  logic        out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = count_r <= CNT_W'(esd_pkg::QUEUE_DEPTH - esd_pkg::MAX_RESULTS);
  assign out_valid = count_r != '0;
  assign out_data  = queue_r[head_r];

  assign c        = in_data.char_in;
  assign hv       = hex_val(c);
  assign seen_inc = seen_r + 4'd1;
  assign cp       = {acc_r[27:0], hv[3:0]};

  always_comb begin
    nres     = 3'd0;
    for (int i = 0; i < esd_pkg::MAX_RESULTS; i++) res[i] = mk_byte(8'h00);
    mode_nxt = mode_r;
    seen_nxt = seen_r;
    need_nxt = need_r;
    acc_nxt  = acc_r;
    if (in_data.end_of_input) begin
      case (mode_r)
        esd_pkg::MODE_BACKSLASH: begin
          res[0] = mk_err(esd_pkg::ERR_END_ESC);
          nres   = 3'd1;
        end
        esd_pkg::MODE_HEX: begin
          res[0] = (seen_r == 4'd0) ? mk_err(esd_pkg::ERR_BAD_HEX) : mk_byte(acc_r[7:0]);
          nres   = 3'd1;
        end
        esd_pkg::MODE_UNICODE: begin
          res[0] = mk_err(esd_pkg::ERR_BAD_UNI);
          nres   = 3'd1;
        end
        default: ;
      endcase
      mode_nxt = esd_pkg::MODE_IDLE;
      seen_nxt = 4'd0;
      need_nxt = 4'd0;
      acc_nxt  = 32'd0;
    end else begin
      case (mode_r)
        esd_pkg::MODE_IDLE: begin
          if (c == CH_BSLASH) begin
            mode_nxt = esd_pkg::MODE_BACKSLASH;
            seen_nxt = 4'd0;
            need_nxt = 4'd0;
            acc_nxt  = 32'd0;
          end else begin
            res[0] = mk_byte(c);
            nres   = 3'd1;
          end
        end
        esd_pkg::MODE_BACKSLASH: begin
          mode_nxt = esd_pkg::MODE_IDLE;
          seen_nxt = 4'd0;
          need_nxt = 4'd0;
          acc_nxt  = 32'd0;
          nres     = 3'd1;
          case (c)
            CH_N:      res[0] = mk_byte(8'h0A);
            CH_T:      res[0] = mk_byte(8'h09);
            CH_R:      res[0] = mk_byte(8'h0D);
            CH_BSLASH: res[0] = mk_byte(8'h5C);
            CH_SQUOTE: res[0] = mk_byte(8'h27);
            CH_DQUOTE: res[0] = mk_byte(8'h22);
            CH_ZERO:   res[0] = mk_byte(8'h00);
            CH_A:      res[0] = mk_byte(8'h07);
            CH_B:      res[0] = mk_byte(8'h08);
            CH_F:      res[0] = mk_byte(8'h0C);
            CH_V:      res[0] = mk_byte(8'h0B);
            CH_X: begin
              mode_nxt = esd_pkg::MODE_HEX;
              need_nxt = 4'd2;
              nres     = 3'd0;
            end
            CH_LU: begin
              mode_nxt = esd_pkg::MODE_UNICODE;
              need_nxt = 4'd4;
              nres     = 3'd0;
            end
            CH_UU: begin
              mode_nxt = esd_pkg::MODE_UNICODE;
              need_nxt = 4'd8;
              nres     = 3'd0;
            end
            default: begin
              res[0] = mk_err(esd_pkg::ERR_UNKNOWN);
              res[1] = mk_byte(c);
              nres   = 3'd2;
            end
          endcase
        end
        esd_pkg::MODE_HEX: begin
          if (!hv[4]) begin
            if (seen_inc >= 4'd2) begin
              res[0]   = mk_byte({acc_r[3:0], hv[3:0]});
              nres     = 3'd1;
              mode_nxt = esd_pkg::MODE_IDLE;
              seen_nxt = 4'd0;
              need_nxt = 4'd0;
              acc_nxt  = 32'd0;
            end else begin
              seen_nxt = seen_inc;
              acc_nxt  = {24'd0, acc_r[3:0], hv[3:0]};
            end
          end else begin
            mode_nxt = esd_pkg::MODE_IDLE;
            seen_nxt = 4'd0;
            need_nxt = 4'd0;
            acc_nxt  = 32'd0;
            nres     = 3'd1;
            if (seen_r == 4'd0) begin
              res[0] = mk_err(esd_pkg::ERR_BAD_HEX);
            end else begin
              res[0] = mk_byte(acc_r[7:0]);
              if (c == CH_BSLASH) begin
                mode_nxt = esd_pkg::MODE_BACKSLASH;
              end else begin
                res[1] = mk_byte(c);
                nres   = 3'd2;
              end
            end
          end
        end
        default: begin
          if (!hv[4]) begin
            if (seen_inc >= need_r) begin
              mode_nxt = esd_pkg::MODE_IDLE;
              seen_nxt = 4'd0;
              need_nxt = 4'd0;
              acc_nxt  = 32'd0;
              if (cp <= 32'h7F) begin
                res[0] = mk_byte(cp[7:0]);
                nres   = 3'd1;
              end else if (cp <= 32'h7FF) begin
                res[0] = mk_byte({3'b110, cp[10:6]});
                res[1] = mk_byte({2'b10, cp[5:0]});
                nres   = 3'd2;
              end else if (cp <= 32'hFFFF) begin
                res[0] = mk_byte({4'b1110, cp[15:12]});
                res[1] = mk_byte({2'b10, cp[11:6]});
                res[2] = mk_byte({2'b10, cp[5:0]});
                nres   = 3'd3;
              end else if (cp <= 32'h10FFFF) begin
                res[0] = mk_byte({5'b11110, cp[20:18]});
                res[1] = mk_byte({2'b10, cp[17:12]});
                res[2] = mk_byte({2'b10, cp[11:6]});
                res[3] = mk_byte({2'b10, cp[5:0]});
                nres   = 3'd4;
              end else begin
                res[0] = mk_err(esd_pkg::ERR_RANGE);
                nres   = 3'd1;
              end
            end else begin
              seen_nxt = seen_inc;
              acc_nxt  = cp;
            end
          end else begin
            res[0]   = mk_err(esd_pkg::ERR_BAD_UNI);
            nres     = 3'd1;
            mode_nxt = esd_pkg::MODE_IDLE;
            seen_nxt = 4'd0;
            need_nxt = 4'd0;
            acc_nxt  = 32'd0;
          end
        end
      endcase
    end
    for (int i = 0; i < esd_pkg::MAX_RESULTS; i++) begin
      res[i].last = (3'(i + 1) == nres);
    end
  end

  always_comb begin
    head_nxt  = out_fire ? head_r + PTR_W'(1) : head_r;
    tail_nxt  = in_fire ? tail_r + PTR_W'(nres) : tail_r;
    count_nxt = count_r + (in_fire ? CNT_W'(nres) : CNT_W'(0)) - CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= esd_pkg::MODE_IDLE;
      seen_r  <= 4'd0;
      need_r  <= 4'd0;
      acc_r   <= 32'd0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (in_fire) begin
        mode_r <= mode_nxt;
        seen_r <= seen_nxt;
        need_r <= need_nxt;
        acc_r  <= acc_nxt;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < esd_pkg::MAX_RESULTS; i++) begin
        if (3'(i) < nres) begin
          queue_r[tail_r + PTR_W'(i)] <= res[i];
        end
      end
    end
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder testbench
// Drives byte beats and end-of-input beats into the decoder and scores every
// result beat against a decoder model kept alongside. It opens with directed
// escapes and end-of-input flushes, then runs random escape sequences with
// noise under four handshake mixes: none, sender gaps, receiver stalls, both.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_BEATS_PER_MIX = 70;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  esd_pkg::esd_in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  esd_pkg::esd_out_t out_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  esd_pkg::esd_out_t decoded_q[$];

  esd_pkg::dec_mode_t dec_mode;
  logic [3:0] digits_seen;
  logic [3:0] digits_needed;
  logic [31:0] code_acc;

  always #5 clk = ~clk;

  escape_sequence_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void emit(logic [7:0] b, logic err, logic [2:0] code);
    esd_pkg::esd_out_t r;
    r.byte_value = b;
    r.is_error = err;
    r.error_code = code;
    r.last = 1'b0;
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function automatic void clear_escape();
    dec_mode = esd_pkg::MODE_IDLE;
    digits_seen = 4'd0;
    digits_needed = 4'd0;
    code_acc = 32'd0;
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c == "\\") begin
      clear_escape();
      dec_mode = esd_pkg::MODE_BACKSLASH;
    end else begin
      emit(c, 1'b0, esd_pkg::ERR_NONE);
    end
  endfunction

  function automatic void emit_utf8(logic [31:0] cp);
    if (cp <= 32'h7F) begin
      emit(cp[7:0], 1'b0, esd_pkg::ERR_NONE);
    end else if (cp <= 32'h7FF) begin
      emit({3'b110, cp[10:6]}, 1'b0, esd_pkg::ERR_NONE);
      emit({2'b10, cp[5:0]}, 1'b0, esd_pkg::ERR_NONE);
    end else if (cp <= 32'hFFFF) begin
      emit({4'b1110, cp[15:12]}, 1'b0, esd_pkg::ERR_NONE);
      emit({2'b10, cp[11:6]}, 1'b0, esd_pkg::ERR_NONE);
      emit({2'b10, cp[5:0]}, 1'b0, esd_pkg::ERR_NONE);
    end else if (cp <= 32'h10FFFF) begin
      emit({5'b11110, cp[20:18]}, 1'b0, esd_pkg::ERR_NONE);
      emit({2'b10, cp[17:12]}, 1'b0, esd_pkg::ERR_NONE);
      emit({2'b10, cp[11:6]}, 1'b0, esd_pkg::ERR_NONE);
      emit({2'b10, cp[5:0]}, 1'b0, esd_pkg::ERR_NONE);
    end else begin
      emit(8'h00, 1'b1, esd_pkg::ERR_RANGE);
    end
  endfunction

  function automatic void decode_beat(esd_pkg::esd_in_t b);
    int d;
    int count_before;
    count_before = decoded_q.size();
    if (b.end_of_input) begin
      case (dec_mode)
        esd_pkg::MODE_BACKSLASH: emit(8'h00, 1'b1, esd_pkg::ERR_END_ESC);
        esd_pkg::MODE_HEX: begin
          if (digits_seen == 4'd0) emit(8'h00, 1'b1, esd_pkg::ERR_BAD_HEX);
          else emit(code_acc[7:0], 1'b0, esd_pkg::ERR_NONE);
        end
        esd_pkg::MODE_UNICODE: emit(8'h00, 1'b1, esd_pkg::ERR_BAD_UNI);
        default: ;
      endcase
      clear_escape();
    end else begin
      case (dec_mode)
        esd_pkg::MODE_IDLE: take_plain(b.char_in);
        esd_pkg::MODE_BACKSLASH: begin
          clear_escape();
          case (b.char_in)
            "n": emit(8'h0A, 1'b0, esd_pkg::ERR_NONE);
            "t": emit(8'h09, 1'b0, esd_pkg::ERR_NONE);
            "r": emit(8'h0D, 1'b0, esd_pkg::ERR_NONE);
            "\\": emit(8'h5C, 1'b0, esd_pkg::ERR_NONE);
            "'": emit(8'h27, 1'b0, esd_pkg::ERR_NONE);
            "\"": emit(8'h22, 1'b0, esd_pkg::ERR_NONE);
            "0": emit(8'h00, 1'b0, esd_pkg::ERR_NONE);
            "a": emit(8'h07, 1'b0, esd_pkg::ERR_NONE);
            "b": emit(8'h08, 1'b0, esd_pkg::ERR_NONE);
            "f": emit(8'h0C, 1'b0, esd_pkg::ERR_NONE);
            "v": emit(8'h0B, 1'b0, esd_pkg::ERR_NONE);
            "x": begin
              dec_mode = esd_pkg::MODE_HEX;
              digits_needed = 4'd2;
            end
            "u": begin
              dec_mode = esd_pkg::MODE_UNICODE;
              digits_needed = 4'd4;
            end
            "U": begin
              dec_mode = esd_pkg::MODE_UNICODE;
              digits_needed = 4'd8;
            end
            default: begin
              emit(8'h00, 1'b1, esd_pkg::ERR_UNKNOWN);
              emit(b.char_in, 1'b0, esd_pkg::ERR_NONE);
            end
          endcase
        end
        esd_pkg::MODE_HEX: begin
          d = hex_value(b.char_in);
          if (d >= 0) begin
            code_acc = {24'h0, code_acc[3:0], d[3:0]};
            digits_seen = digits_seen + 4'd1;
            if (digits_seen >= 4'd2) begin
              emit(code_acc[7:0], 1'b0, esd_pkg::ERR_NONE);
              clear_escape();
            end
          end else if (digits_seen == 4'd0) begin
            emit(8'h00, 1'b1, esd_pkg::ERR_BAD_HEX);
            clear_escape();
          end else begin
            emit(code_acc[7:0], 1'b0, esd_pkg::ERR_NONE);
            clear_escape();
            take_plain(b.char_in);
          end
        end
        default: begin
          d = hex_value(b.char_in);
          if (d >= 0) begin
            code_acc = {code_acc[27:0], d[3:0]};
            digits_seen = digits_seen + 4'd1;
            if (digits_seen >= digits_needed) begin
              emit_utf8(code_acc);
              clear_escape();
            end
          end else begin
            emit(8'h00, 1'b1, esd_pkg::ERR_BAD_UNI);
            clear_escape();
          end
        end
      endcase
    end
    if (decoded_q.size() > count_before) begin
      decoded_q[decoded_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void report_mismatch(string what, esd_pkg::esd_out_t want,
                                          esd_pkg::esd_out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch (%s): expected byte=%02h err=%0b code=%0d last=%0b,",
               what, want.byte_value, want.is_error, want.error_code, want.last);
      $display("  got byte=%02h err=%0b code=%0d last=%0b",
               got.byte_value, got.is_error, got.error_code, got.last);
    end
  endfunction

  function automatic void score_result(esd_pkg::esd_out_t got);
    esd_pkg::esd_out_t want;
    results_checked++;
    if (decoded_q.size() == 0) begin
      want = '0;
      report_mismatch("nothing pending", want, got);
    end else begin
      want = decoded_q.pop_front();
      if (got.byte_value !== want.byte_value || got.is_error !== want.is_error ||
          got.error_code !== want.error_code || got.last !== want.last) begin
        report_mismatch("field", want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decode_beat(in_data);
      if (out_valid && out_ready) score_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("escape_sequence_decoder regression: fail");
    $finish;
  end

  task automatic send_beat(esd_pkg::esd_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    esd_pkg::esd_in_t b;
    b.char_in = c;
    b.end_of_input = 1'b0;
    send_beat(b);
  endtask

  task automatic send_end();
    esd_pkg::esd_in_t b;
    b.char_in = 8'($urandom_range(255));
    b.end_of_input = 1'b1;
    send_beat(b);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return "0" + {4'd0, v};
    if ($urandom_range(1)) return "A" + {4'd0, v} - 8'd10;
    return "a" + {4'd0, v} - 8'd10;
  endfunction

  task automatic send_hex(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) send_char(hex_char(v[4*i +: 4]));
  endtask

  task automatic send_escape(logic [7:0] c);
    send_char("\\");
    send_char(c);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] simple_escape_char(int k);
    case (k)
      0: return "n";
      1: return "t";
      2: return "r";
      3: return "\\";
      4: return "'";
      5: return "\"";
      6: return "0";
      7: return "a";
      8: return "b";
      9: return "f";
      default: return "v";
    endcase
  endfunction

  function automatic bit is_known_escape(logic [7:0] c);
    for (int k = 0; k < 11; k++) if (c == simple_escape_char(k)) return 1'b1;
    return (c == "x" || c == "u" || c == "U");
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (hex_value(c) >= 0);
    return c;
  endfunction

  function automatic logic [31:0] random_code_point(int cls);
    logic [31:0] cp;
    case (cls)
      0: cp = $urandom_range(32'h7F);
      1: cp = $urandom_range(32'h7FF, 32'h80);
      2: cp = $urandom_range(32'hFFFF, 32'h800);
      3: cp = $urandom_range(32'h10FFFF, 32'h10000);
      default: cp = $urandom | 32'h0011_0000;
    endcase
    return cp;
  endfunction

  task automatic send_broken_escape();
    int k;
    case ($urandom_range(3))
      0: begin
        send_escape("x");
        send_char(random_non_hex());
      end
      1: begin
        send_escape($urandom_range(1) ? "u" : "U");
        k = $urandom_range(3);
        send_hex($urandom, k);
        send_char(random_non_hex());
      end
      2: begin
        send_char("\\");
        send_end();
      end
      default: begin
        send_escape(($urandom_range(1) ? "x" : "U"));
        send_hex($urandom, $urandom_range(1));
        send_end();
      end
    endcase
  endtask

  task automatic send_random_run(int beats);
    int target;
    logic [7:0] c;
    esd_pkg::esd_in_t b;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          c = 8'($urandom_range(255));
          if (c == "\\") c = 8'h5D;
          send_char(c);
        end
        5, 6, 7: send_escape(simple_escape_char($urandom_range(10)));
        8, 9: begin
          send_escape("x");
          send_hex($urandom_range(255), 2);
        end
        10: begin
          send_escape("x");
          send_hex($urandom_range(15), 1);
          send_char(random_non_hex());
        end
        11, 12: begin
          send_escape("u");
          send_hex(random_code_point($urandom_range(2)), 4);
        end
        13, 14: begin
          send_escape("U");
          send_hex(random_code_point($urandom_range(4)), 8);
        end
        15: begin
          do c = 8'($urandom_range(255)); while (is_known_escape(c));
          send_escape(c);
        end
        16: send_broken_escape();
        17: send_end();
        default: begin
          b.char_in = 8'($urandom_range(255));
          b.end_of_input = ($urandom_range(7) == 0);
          send_beat(b);
        end
      endcase
    end
  endtask

  task automatic test_plain_extremes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char("A");
    send_end();
    pause_until_drained();
  endtask

  task automatic test_end_flush();
    send_char("\\");
    send_end();
    send_escape("x");
    send_end();
    send_escape("x");
    send_char("F");
    send_end();
    send_escape("U");
    send_char("1");
    send_end();
    pause_until_drained();
  endtask

  task automatic test_hex_escapes();
    send_escape("x");
    send_char("g");
    send_escape("x");
    send_char("7");
    send_escape("n");
    send_escape("x");
    send_hex(32'hFF, 2);
    pause_until_drained();
  endtask

  task automatic test_unicode_escapes();
    send_escape("u");
    send_char("1");
    send_char("z");
    send_escape("u");
    send_hex(32'hD800, 4);
    send_escape("U");
    send_hex(32'hFFFF_FFFF, 8);
    send_escape("q");
    pause_until_drained();
  endtask

  task automatic test_random_mix(int idle_pct, int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    send_random_run(RANDOM_BEATS_PER_MIX);
    pause_until_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    clear_escape();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_extremes();
    test_end_flush();
    test_hex_escapes();
    test_unicode_escapes();
    test_random_mix(0, 0);
    test_random_mix(62, 0);
    test_random_mix(0, 62);
    test_random_mix(33, 33);

    repeat (16) @(posedge clk);
    $display("covered %0d input beats: directed escapes and flushes, then random sequences",
             beats_sent);
    $display("under four handshake mixes; %0d result beats scored, %0d mismatching",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("escape_sequence_decoder regression: pass");
    end else begin
      $display("escape_sequence_decoder regression: fail");
    end
    $finish;
  end

endmodule

### escape_sequence_decoder.f
hdl/esd_pkg.sv
hdl/escape_sequence_decoder.sv
tb/sv/testbench.sv
